// ===== rtl/core/packet_ring_fifo_with_drop_count_unit_defines.svh =====
// Assertion macros used by the checker file of the packet ring FIFO.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef PACKET_RING_FIFO_WITH_DROP_COUNT_UNIT_DEFINES_SVH
`define PACKET_RING_FIFO_WITH_DROP_COUNT_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("packet ring FIFO check failed");

// The consequent must hold in the cycle after the antecedent.
`define PRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("packet ring FIFO check failed");

`endif

// ===== rtl/core/prf_pkg.sv =====
// Shared constants, codes and beat types of the packet ring FIFO.
// Depends on nothing; used by every module of the block except the RAM.
`default_nettype none

package prf_pkg;

    localparam int SLOT_COUNT  = 16;
    localparam int SNAP_BYTES  = 2048;
    localparam int STORE_DEPTH = SLOT_COUNT * SNAP_BYTES;

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int OFF_W  = $clog2(SNAP_BYTES + 1);

    localparam int OP_W     = 2;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int LEN_W    = 12;
    localparam int DROP_W   = 64;
    localparam int QUEUED_W = 5;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLOSE = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED       = 3'd0,
        ST_DROPPED        = 3'd1,
        ST_DELIVERED      = 3'd2,
        ST_EMPTY          = 3'd3,
        ST_CLOSED_DRAINED = 3'd4
    } status_t;

    typedef struct packed {
        status_t             status;
        logic                eop;
        logic [LEN_W-1:0]    plen;
        logic [DROP_W-1:0]   drop;
        logic [QUEUED_W-1:0] queued;
        logic                rd_en;
    } desc_t;

    typedef struct packed {
        status_t             status;
        logic [BYTE_W-1:0]   data;
        logic                eop;
        logic [LEN_W-1:0]    plen;
        logic [DROP_W-1:0]   drop;
        logic [QUEUED_W-1:0] queued;
    } res_t;

    function automatic logic [ADDR_W-1:0] store_addr(input logic [SLOT_W-1:0] slot,
                                                     input logic [OFF_W-1:0] offset);
        return ADDR_W'(slot) * ADDR_W'(SNAP_BYTES) + ADDR_W'(offset);
    endfunction

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] slot);
        return (slot == SLOT_W'(SLOT_COUNT - 1)) ? '0 : slot + SLOT_W'(1);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/packet_ring_fifo_with_drop_count_unit.sv =====
// Each request beat's result passes through the stage register and the result queue before it is offered.
// Throughput: one beat per cycle; the byte store read port and the four-entry
// result queue set the pace, and the request side stalls once the queue is committed.
// Reset: asynchronous, active low; clears pointers, flags, drop count and the queue.
// The byte store and slot lengths are not cleared; they are only read once written.
`default_nettype none

module packet_ring_fifo_with_drop_count_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              req_valid,
    output logic                                   req_stall,
    input  wire logic [prf_pkg::OP_W-1:0]          operation,
    input  wire logic [prf_pkg::BYTE_W-1:0]        data_byte,
    input  wire logic                              has_byte,
    input  wire logic                              last_byte,
    output logic                                   rsp_valid,
    input  wire logic                              rsp_stall,
    output logic [prf_pkg::STATUS_W-1:0]           status,
    output logic [prf_pkg::BYTE_W-1:0]             data_out,
    output logic                                   end_of_packet,
    output logic [prf_pkg::LEN_W-1:0]              packet_length,
    output logic [prf_pkg::DROP_W-1:0]             drop_total,
    output logic [prf_pkg::QUEUED_W-1:0]           queued_packets
);

    logic                        take_ok;
    logic                        desc_valid;
    prf_pkg::desc_t              desc;
    logic                        ram_wr_en;
    logic [prf_pkg::ADDR_W-1:0]  ram_wr_addr;
    logic [prf_pkg::BYTE_W-1:0]  ram_wr_data;
    logic                        ram_rd_en;
    logic [prf_pkg::ADDR_W-1:0]  ram_rd_addr;
    logic [prf_pkg::BYTE_W-1:0]  ram_q;
    prf_pkg::res_t               res;

    prf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .operation   (operation),
        .data_byte   (data_byte),
        .has_byte    (has_byte),
        .last_byte   (last_byte),
        .take_ok     (take_ok),
        .desc_valid  (desc_valid),
        .desc        (desc),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr)
    );

    prf_ram #(
        .DATA_W (prf_pkg::BYTE_W),
        .DEPTH  (prf_pkg::STORE_DEPTH)
    ) u_byte_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_q)
    );

    prf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (desc_valid),
        .desc       (desc),
        .ram_q      (ram_q),
        .take_ok    (take_ok),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .res        (res)
    );

    assign status         = res.status;
    assign data_out       = res.data;
    assign end_of_packet  = res.eop;
    assign packet_length  = res.plen;
    assign drop_total     = res.drop;
    assign queued_packets = res.queued;

endmodule

`default_nettype wire

// ===== rtl/core/prf_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing; holds the packet bytes of the ring.
`default_nettype none

module prf_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 32768
) (
    input  wire logic                      clk,
    input  wire logic                      wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  wire logic [DATA_W-1:0]         wr_data,
    input  wire logic                      rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
    output logic      [DATA_W-1:0]         rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/prf_front.sv =====
// Front part: accepts request beats, keeps the ring pointers, flags and drop count,
// and issues the byte store access. Depends on prf_pkg.
`default_nettype none

module prf_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            req_valid,
    output logic                                 req_stall,
    input  wire logic [prf_pkg::OP_W-1:0]        operation,
    input  wire logic [prf_pkg::BYTE_W-1:0]      data_byte,
    input  wire logic                            has_byte,
    input  wire logic                            last_byte,
    input  wire logic                            take_ok,
    output logic                                 desc_valid,
    output prf_pkg::desc_t                       desc,
    output logic                                 ram_wr_en,
    output logic [prf_pkg::ADDR_W-1:0]           ram_wr_addr,
    output logic [prf_pkg::BYTE_W-1:0]           ram_wr_data,
    output logic                                 ram_rd_en,
    output logic [prf_pkg::ADDR_W-1:0]           ram_rd_addr
);

    logic [prf_pkg::SLOT_W-1:0] head_reg, head_next;
    logic [prf_pkg::SLOT_W-1:0] tail_reg, tail_next;
    logic [prf_pkg::CNT_W-1:0]  total_reg, total_next;
    logic                       closed_reg, closed_next;
    logic [prf_pkg::DROP_W-1:0] drop_reg, drop_next;
    logic [prf_pkg::OFF_W-1:0]  woff_reg, woff_next;
    logic [prf_pkg::OFF_W-1:0]  roff_reg, roff_next;
    logic                       in_pkt_reg, in_pkt_next;
    logic                       disc_reg, disc_next;

    logic [prf_pkg::OFF_W-1:0]  slot_len_reg [prf_pkg::SLOT_COUNT];

    logic                       accept;
    logic                       start;
    logic                       slot_full;
    logic                       drop_now;
    logic                       room;
    logic                       len_we;
    logic                       wr_en;
    logic                       rd_en;
    logic [prf_pkg::OFF_W-1:0]  woff_eff;
    logic [prf_pkg::OFF_W-1:0]  woff_new;
    logic [prf_pkg::OFF_W-1:0]  len_head;
    logic [prf_pkg::OFF_W-1:0]  roff_inc;
    prf_pkg::desc_t             d;

    assign accept    = req_valid && take_ok;
    assign req_stall = !take_ok;

    assign slot_full = (total_reg == prf_pkg::CNT_W'(prf_pkg::SLOT_COUNT));
    assign start     = !in_pkt_reg && !disc_reg;
    assign drop_now  = start && (closed_reg || slot_full);
    assign woff_eff  = start ? '0 : woff_reg;
    assign room      = (woff_eff < prf_pkg::OFF_W'(prf_pkg::SNAP_BYTES));
    assign woff_new  = (has_byte && room) ? woff_eff + prf_pkg::OFF_W'(1) : woff_eff;
    assign len_head  = slot_len_reg[head_reg];
    assign roff_inc  = (roff_reg < len_head) ? roff_reg + prf_pkg::OFF_W'(1) : roff_reg;

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        total_next  = total_reg;
        closed_next = closed_reg;
        drop_next   = drop_reg;
        woff_next   = woff_reg;
        roff_next   = roff_reg;
        in_pkt_next = in_pkt_reg;
        disc_next   = disc_reg;
        len_we      = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        d           = '0;
        d.status    = prf_pkg::ST_ACCEPTED;
        if (accept)
        begin
            unique case (operation)
                prf_pkg::OP_PUSH:
                begin
                    if (drop_now || disc_reg)
                    begin
                        d.status  = prf_pkg::ST_DROPPED;
                        disc_next = !last_byte;
                        if (drop_now)
                        begin
                            drop_next = drop_reg + prf_pkg::DROP_W'(1);
                        end
                    end
                    else
                    begin
                        wr_en = has_byte && room;
                        if (last_byte)
                        begin
                            len_we      = 1'b1;
                            tail_next   = prf_pkg::next_slot(tail_reg);
                            total_next  = total_reg + prf_pkg::CNT_W'(1);
                            in_pkt_next = 1'b0;
                            woff_next   = '0;
                        end
                        else
                        begin
                            in_pkt_next = 1'b1;
                            woff_next   = woff_new;
                        end
                    end
                end
                prf_pkg::OP_POP:
                begin
                    if (total_reg == '0)
                    begin
                        d.status = closed_reg ? prf_pkg::ST_CLOSED_DRAINED
                                              : prf_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        d.status = prf_pkg::ST_DELIVERED;
                        d.plen   = prf_pkg::LEN_W'(len_head);
                        rd_en    = (roff_reg < len_head);
                        if (roff_inc >= len_head)
                        begin
                            d.eop      = 1'b1;
                            roff_next  = '0;
                            head_next  = prf_pkg::next_slot(head_reg);
                            total_next = total_reg - prf_pkg::CNT_W'(1);
                        end
                        else
                        begin
                            roff_next = roff_inc;
                        end
                    end
                end
                prf_pkg::OP_CLOSE:
                begin
                    closed_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        d.rd_en  = rd_en;
        d.drop   = drop_next;
        d.queued = prf_pkg::QUEUED_W'(total_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            total_reg  <= '0;
            closed_reg <= 1'b0;
            drop_reg   <= '0;
            woff_reg   <= '0;
            roff_reg   <= '0;
            in_pkt_reg <= 1'b0;
            disc_reg   <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            total_reg  <= total_next;
            closed_reg <= closed_next;
            drop_reg   <= drop_next;
            woff_reg   <= woff_next;
            roff_reg   <= roff_next;
            in_pkt_reg <= in_pkt_next;
            disc_reg   <= disc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            slot_len_reg[tail_reg] <= woff_new;
        end
    end

    assign desc_valid  = accept;
    assign desc        = d;
    assign ram_wr_en   = wr_en;
    assign ram_wr_addr = prf_pkg::store_addr(tail_reg, woff_eff);
    assign ram_wr_data = data_byte;
    assign ram_rd_en   = rd_en;
    assign ram_rd_addr = prf_pkg::store_addr(head_reg, roff_reg);

endmodule

`default_nettype wire

// ===== rtl/core/prf_back.sv =====
// Back part: aligns each classified beat with the byte store read data and
// queues the finished results toward the response port. Depends on prf_pkg.
`default_nettype none

module prf_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        desc_valid,
    input  wire prf_pkg::desc_t              desc,
    input  wire logic [prf_pkg::BYTE_W-1:0]  ram_q,
    output logic                             take_ok,
    output logic                             rsp_valid,
    input  wire logic                        rsp_stall,
    output prf_pkg::res_t                    res
);

    logic                        stage_valid_reg;
    prf_pkg::desc_t              stage_reg;
    prf_pkg::res_t               queue_reg [prf_pkg::QUEUE_DEPTH];
    logic [prf_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [prf_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [prf_pkg::QCNT_W-1:0]  count_reg, count_next;
    logic [prf_pkg::QCNT_W:0]    committed;
    logic                        push;
    logic                        pop;
    prf_pkg::res_t               stage_res;

    always_comb
    begin
        stage_res.status = stage_reg.status;
        stage_res.data   = stage_reg.rd_en ? ram_q : '0;
        stage_res.eop    = stage_reg.eop;
        stage_res.plen   = stage_reg.plen;
        stage_res.drop   = stage_reg.drop;
        stage_res.queued = stage_reg.queued;
    end

    assign committed = (prf_pkg::QCNT_W + 1)'(count_reg)
                     + (prf_pkg::QCNT_W + 1)'(stage_valid_reg);
    assign take_ok   = (committed < (prf_pkg::QCNT_W + 1)'(prf_pkg::QUEUE_DEPTH));

    assign rsp_valid = (count_reg != '0);
    assign push      = stage_valid_reg;
    assign pop       = rsp_valid && !rsp_stall;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + prf_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + prf_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + prf_pkg::QCNT_W'(push) - prf_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            count_reg       <= '0;
        end
        else
        begin
            stage_valid_reg <= desc_valid;
            wr_ptr_reg      <= wr_ptr_next;
            rd_ptr_reg      <= rd_ptr_next;
            count_reg       <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (desc_valid)
        begin
            stage_reg <= desc;
        end
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= stage_res;
        end
    end

    assign res = queue_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// ===== rtl/core/prf_checker.sv =====
// Port-level checks of the packet ring FIFO, bound to its top level.
// Depends on prf_pkg and the shared assertion macro header.
`default_nettype none
`include "packet_ring_fifo_with_drop_count_unit_defines.svh"

module prf_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              rsp_valid,
    input wire logic                              rsp_stall,
    input wire logic [prf_pkg::STATUS_W-1:0]      status,
    input wire logic [prf_pkg::BYTE_W-1:0]        data_out,
    input wire logic                              end_of_packet,
    input wire logic [prf_pkg::LEN_W-1:0]         packet_length,
    input wire logic [prf_pkg::DROP_W-1:0]        drop_total,
    input wire logic [prf_pkg::QUEUED_W-1:0]      queued_packets
);

    `PRF_ASSERT_NEXT(a_rsp_held, clk, rst_n, rsp_valid && rsp_stall, rsp_valid)
    `PRF_ASSERT_NEXT(a_rsp_stable, clk, rst_n, rsp_valid && rsp_stall,
        $stable(status) && $stable(drop_total) && $stable(queued_packets))
    `PRF_ASSERT_SAME(a_quiet_fields, clk, rst_n,
        rsp_valid && (status != prf_pkg::ST_DELIVERED),
        (data_out == '0) && !end_of_packet && (packet_length == '0))
    `PRF_ASSERT_SAME(a_empty_ring, clk, rst_n,
        rsp_valid && ((status == prf_pkg::ST_EMPTY) ||
                      (status == prf_pkg::ST_CLOSED_DRAINED)),
        queued_packets == '0)

endmodule

bind packet_ring_fifo_with_drop_count_unit prf_checker u_checker (.*);

`default_nettype wire

// ===== test/packet_ring_fifo_with_drop_count_unit_checker.sv =====
`timescale 1ns / 1ps
// Checker for the packet ring FIFO: watches the request and response channels, predicts
// every response beat from its own copy of the ring state and compares field by field.
// Depends on prf_pkg for widths, operation and status codes and the result beat type.

module packet_ring_fifo_with_drop_count_unit_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_stall,
    input  logic [prf_pkg::OP_W-1:0]      operation,
    input  logic [prf_pkg::BYTE_W-1:0]    data_byte,
    input  logic                          has_byte,
    input  logic                          last_byte,
    input  logic                          rsp_valid,
    input  logic                          rsp_stall,
    input  logic [prf_pkg::STATUS_W-1:0]  status,
    input  logic [prf_pkg::BYTE_W-1:0]    data_out,
    input  logic                          end_of_packet,
    input  logic [prf_pkg::LEN_W-1:0]     packet_length,
    input  logic [prf_pkg::DROP_W-1:0]    drop_total,
    input  logic [prf_pkg::QUEUED_W-1:0]  queued_packets,
    output int                            fail_count,
    output int                            outstanding,
    output int                            request_beats,
    output int                            result_beats,
    output int                            bytes_delivered,
    output logic [prf_pkg::DROP_W-1:0]    packets_dropped
);
    import prf_pkg::*;

    logic [BYTE_W-1:0]   ring_bytes [STORE_DEPTH];
    logic [LEN_W-1:0]    ring_lengths [SLOT_COUNT];
    logic [SLOT_W-1:0]   head_slot = '0;
    logic [SLOT_W-1:0]   tail_slot = '0;
    logic [QUEUED_W-1:0] packets_held = '0;
    logic                queue_closed = 1'b0;
    logic [DROP_W-1:0]   drops_seen = '0;
    logic [OFF_W-1:0]    write_pos = '0;
    logic [OFF_W-1:0]    read_pos = '0;
    logic                filling = 1'b0;
    logic                discarding = 1'b0;
    res_t                results_due [$];

    assign packets_dropped = drops_seen;

    function automatic logic [SLOT_W-1:0] advance_slot(input logic [SLOT_W-1:0] slot);
        return (slot == SLOT_W'(SLOT_COUNT - 1)) ? '0 : slot + 1'b1;
    endfunction

    function automatic int store_index(input logic [SLOT_W-1:0] slot,
                                       input logic [OFF_W-1:0] offset);
        return int'(slot) * SNAP_BYTES + int'(offset);
    endfunction

    // Applies one request beat to the ring copy and returns the response it must produce.
    function automatic res_t ring_response(input logic [OP_W-1:0] op,
                                           input logic [BYTE_W-1:0] byte_in,
                                           input logic carries_byte,
                                           input logic ends_packet);
        res_t             r;
        logic [LEN_W-1:0] len;
        r = '0;
        r.status = ST_ACCEPTED;
        if (op == OP_PUSH)
        begin
            if (!filling && !discarding)
            begin
                if (queue_closed || packets_held >= SLOT_COUNT)
                begin
                    drops_seen = drops_seen + 1'b1;
                    discarding = 1'b1;
                end
                else
                begin
                    filling = 1'b1;
                    write_pos = '0;
                end
            end
            if (discarding)
            begin
                r.status = ST_DROPPED;
                if (ends_packet)
                    discarding = 1'b0;
            end
            else
            begin
                if (carries_byte && write_pos < SNAP_BYTES)
                begin
                    ring_bytes[store_index(tail_slot, write_pos)] = byte_in;
                    write_pos = write_pos + 1'b1;
                end
                if (ends_packet)
                begin
                    ring_lengths[tail_slot] = LEN_W'(write_pos);
                    tail_slot = advance_slot(tail_slot);
                    packets_held = packets_held + 1'b1;
                    filling = 1'b0;
                    write_pos = '0;
                end
            end
        end
        else if (op == OP_POP)
        begin
            if (packets_held == 0)
                r.status = queue_closed ? ST_CLOSED_DRAINED : ST_EMPTY;
            else
            begin
                len = ring_lengths[head_slot];
                r.status = ST_DELIVERED;
                r.plen = len;
                if (read_pos < len)
                begin
                    r.data = ring_bytes[store_index(head_slot, read_pos)];
                    read_pos = read_pos + 1'b1;
                end
                if (read_pos >= len)
                begin
                    r.eop = 1'b1;
                    read_pos = '0;
                    head_slot = advance_slot(head_slot);
                    packets_held = packets_held - 1'b1;
                end
            end
        end
        else if (op == OP_CLOSE)
            queue_closed = 1'b1;
        r.drop = drops_seen;
        r.queued = packets_held;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (fail_count < 50)
            $display("MISMATCH at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("result beat %0d, %s: got %0h, expected %0h",
                                      result_beats, name, got, want));
    endtask

    always @(posedge clk)
    begin : watch_channels
        res_t want;
        if (rst_n === 1'b1)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (results_due.size() == 0)
                    report_mismatch($sformatf("result beat %0d arrived with nothing expected",
                                              result_beats));
                else
                begin
                    want = results_due.pop_front();
                    check_field("status", status, want.status);
                    check_field("data_out", data_out, want.data);
                    check_field("end_of_packet", end_of_packet, want.eop);
                    check_field("packet_length", packet_length, want.plen);
                    check_field("drop_total", drop_total, want.drop);
                    check_field("queued_packets", queued_packets, want.queued);
                    if (want.status == ST_DELIVERED && want.plen != 0)
                        bytes_delivered++;
                end
                result_beats++;
            end
            if (req_valid && !req_stall)
            begin
                results_due.push_back(ring_response(operation, data_byte, has_byte, last_byte));
                request_beats++;
            end
            outstanding = results_due.size();
        end
    end

endmodule

// ===== test/packet_ring_fifo_with_drop_count_unit_tb.sv =====
`timescale 1ns / 1ps
// Top of the packet ring FIFO testbench: clock, reset, request beats, response stalls
// and the verdict. Depends on prf_pkg, the block and the checker module.

module packet_ring_fifo_with_drop_count_unit_tb;
    import prf_pkg::*;

    localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;
    localparam int MAX_PKT_BYTES = 40;
    localparam int DRAIN_POPS    = SLOT_COUNT * (MAX_PKT_BYTES + 1);

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_stall;
    logic [OP_W-1:0]      operation;
    logic [BYTE_W-1:0]    data_byte;
    logic                 has_byte;
    logic                 last_byte;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    logic [STATUS_W-1:0]  status;
    logic [BYTE_W-1:0]    data_out;
    logic                 end_of_packet;
    logic [LEN_W-1:0]     packet_length;
    logic [DROP_W-1:0]    drop_total;
    logic [QUEUED_W-1:0]  queued_packets;

    int                   fail_count;
    int                   outstanding;
    int                   request_beats;
    int                   result_beats;
    int                   bytes_delivered;
    logic [DROP_W-1:0]    packets_dropped;

    int                   send_idle_pct = 22;
    int                   recv_idle_pct = 85;
    int                   beats_sent = 0;

    packet_ring_fifo_with_drop_count_unit dut (.*);

    packet_ring_fifo_with_drop_count_unit_checker ring_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge clk)
        rsp_stall <= (int'($urandom_range(99)) < recv_idle_pct);

    task automatic send_beat(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] byte_in,
                             input logic carries_byte, input logic ends_packet);
        while (int'($urandom_range(99)) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        operation <= op;
        data_byte <= byte_in;
        has_byte <= carries_byte;
        last_byte <= ends_packet;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic push_packet(input int n_bytes);
        int  pushed;
        bit  bare_end;
        pushed = 0;
        bare_end = (n_bytes == 0) || ($urandom_range(3) == 0);
        while (pushed < n_bytes)
        begin
            if ($urandom_range(9) == 0)
                send_beat(OP_PUSH, BYTE_W'($urandom), 1'b0, 1'b0);
            else
            begin
                pushed++;
                send_beat(OP_PUSH, BYTE_W'($urandom), 1'b1, (pushed == n_bytes) && !bare_end);
            end
        end
        if (bare_end)
            send_beat(OP_PUSH, BYTE_W'($urandom), 1'b0, 1'b1);
    endtask

    task automatic pop_burst(input int n_pops);
        repeat (n_pops)
            send_beat(OP_POP, BYTE_W'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic wait_for_results();
        req_valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        @(posedge clk);
    endtask

    // Alternates between filling and draining stretches so the ring often runs full.
    task automatic run_traffic(input int n_beats, input bit allow_close);
        int stop_at;
        int pick;
        bit filling_up;
        stop_at = beats_sent + n_beats;
        filling_up = 1'b1;
        while (beats_sent < stop_at)
        begin
            if ($urandom_range(7) == 0)
                filling_up = !filling_up;
            pick = $urandom_range(99);
            if (pick < (filling_up ? 70 : 25))
                push_packet(($urandom_range(6) == 0) ? $urandom_range(MAX_PKT_BYTES, 7)
                                                     : $urandom_range(6));
            else if (pick < 92)
                pop_burst($urandom_range(12, 1));
            else if (allow_close && pick < 95)
                send_beat(OP_CLOSE, BYTE_W'($urandom), 1'($urandom), 1'($urandom));
            else
            begin
                send_beat(OP_UNKNOWN, BYTE_W'($urandom), 1'($urandom), 1'($urandom));
                stop_at++;
            end
        end
    endtask

    initial
    begin
        int i;
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        operation <= OP_PUSH;
        data_byte <= '0;
        has_byte <= 1'b0;
        last_byte <= 1'b0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        pop_burst(1);
        send_beat(OP_UNKNOWN, 8'hFF, 1'b1, 1'b1);
        send_beat(OP_PUSH, 8'h00, 1'b0, 1'b1);
        pop_burst(1);
        send_beat(OP_PUSH, 8'h00, 1'b1, 1'b0);
        send_beat(OP_PUSH, 8'h5A, 1'b0, 1'b0);
        send_beat(OP_PUSH, 8'hFF, 1'b1, 1'b1);
        for (i = 1; i < SLOT_COUNT; i++)
            send_beat(OP_PUSH, BYTE_W'(i * 17), 1'b1, 1'b1);
        send_beat(OP_PUSH, 8'h3C, 1'b1, 1'b0);
        send_beat(OP_PUSH, 8'hC3, 1'b1, 1'b1);
        wait_for_results();

        run_traffic(280, 1'b0);
        wait_for_results();
        send_idle_pct = 85;
        recv_idle_pct = 22;
        run_traffic(280, 1'b0);
        wait_for_results();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_traffic(280, 1'b0);

        // Empty the ring so that the next packet is admitted.
        pop_burst(DRAIN_POPS);

        // Close in the middle of an admitted packet, then everything new is dropped.
        send_beat(OP_PUSH, BYTE_W'($urandom), 1'b1, 1'b0);
        send_beat(OP_CLOSE, 8'h00, 1'b0, 1'b0);
        send_beat(OP_PUSH, BYTE_W'($urandom), 1'b1, 1'b0);
        send_beat(OP_PUSH, BYTE_W'($urandom), 1'b1, 1'b1);
        push_packet(3);
        send_beat(OP_CLOSE, 8'hFF, 1'b1, 1'b1);
        send_beat(OP_UNKNOWN, 8'h00, 1'b0, 1'b0);
        run_traffic(120, 1'b1);
        pop_burst(5);

        wait_for_results();
        repeat (10)
            @(posedge clk);
        $display("Covered %0d request beats and %0d response beats, %0d bytes delivered, %0d drops,",
                 request_beats, result_beats, bytes_delivered, packets_dropped);
        $display("with a full ring, empty packets, a drained ring and a close mid-packet.");
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
